FILE: rtl/rsi_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and register indexes of the ray and segment intersection core.
package rsi_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH   = 3'd4;

   // Magnitudes of the cross-product numerator and denominator.
   localparam int AN_W = 52;
   localparam int AD_W = 51;

   // Integer bits of the quotient kept by the divider.
   localparam int QINT_W = 32;

   // Request data that rides alongside the divider.
   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic               reject;
      logic               den_pos;
   } rsi_side_type;

   typedef struct packed {
      logic         valid;
      rsi_side_type side;
   } rsi_flow_type;

endpackage

FILE: rtl/rsi_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module rsi_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  rsi_pkg::rsi_flow_type           in_flow,
   input  logic [rsi_pkg::AN_W-1:0]        in_an,
   input  logic [rsi_pkg::AD_W-1:0]        in_ad,
   output rsi_pkg::rsi_flow_type           out_flow,
   output logic [rsi_pkg::QINT_W+FRAC_BITS-1:0] out_quo,
   output logic                            out_big
);

   localparam int QW   = rsi_pkg::QINT_W + FRAC_BITS;
   localparam int AN_W = rsi_pkg::AN_W;
   localparam int AD_W = rsi_pkg::AD_W;

   logic                  v_ff    [0:QW];
   rsi_pkg::rsi_side_type side_ff [0:QW];
   logic [AD_W-1:0]       r_ff    [0:QW];
   logic [AD_W-1:0]       ad_ff   [0:QW];
   logic [QW-1:0]         n_ff    [0:QW];
   logic [QW-1:0]         q_ff    [0:QW];
   logic                  big_ff  [0:QW];

   logic big_in;

   // The quotient fits in QW bits only when an < ad * 2^32.
   assign big_in = {{(AD_W+rsi_pkg::QINT_W-AN_W){1'b0}}, in_an} >=
                   {in_ad, {rsi_pkg::QINT_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_flow.valid;
      end
      if (adv) begin
         side_ff[0] <= in_flow.side;
         r_ff[0]    <= AD_W'(in_an >> rsi_pkg::QINT_W);
         ad_ff[0]   <= in_ad;
         n_ff[0]    <= {in_an[rsi_pkg::QINT_W-1:0], {FRAC_BITS{1'b0}}};
         q_ff[0]    <= '0;
         big_ff[0]  <= big_in;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [AD_W:0] t;
      logic          ge;
      logic [AD_W-1:0] r_in;

      assign t    = {r_ff[k], n_ff[k][QW-1]};
      assign ge   = t >= {1'b0, ad_ff[k]};
      assign r_in = ge ? AD_W'(t - {1'b0, ad_ff[k]}) : t[AD_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
            r_ff[k+1]    <= r_in;
            ad_ff[k+1]   <= ad_ff[k];
            n_ff[k+1]    <= {n_ff[k][QW-2:0], 1'b0};
            q_ff[k+1]    <= {q_ff[k][QW-2:0], ge};
            big_ff[k+1]  <= big_ff[k];
         end
      end
   end

   assign out_flow.valid = v_ff[QW];
   assign out_flow.side  = side_ff[QW];
   assign out_quo        = q_ff[QW];
   assign out_big        = big_ff[QW];

endmodule

FILE: rtl/ray_segment_intersect_core.sv
`timescale 1ns / 1ps
// Top level of the 2D ray against line segment intersection core.
//
// Each request carries one ray (origin and direction, Q-format fixed point with
// FRAC_BITS fraction bits) and yields exactly one response: whether the ray hits
// the configured segment, the hit point, the unit normal turned to face the ray
// and the ray parameter at the hit, saturated to 31 bits. When there is no hit,
// every response field is zero. The core is fully pipelined and accepts one
// request per clock while req_stall is low; its depth is set mostly by the
// restoring divider, which resolves one of its 32 + FRAC_BITS quotient bits per
// stage. The whole pipeline advances together; req_stall is raised only while a
// response is held in the output register and the consumer stalls it.
// The segment registers are written through the csr_ port, which is always
// ready, and must only be changed while no request is in flight.
module ray_segment_intersect_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_ray_origin_x,
   input  logic signed [31:0]  req_ray_origin_y,
   input  logic signed [31:0]  req_ray_dir_x,
   input  logic signed [31:0]  req_ray_dir_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic signed [31:0]  rsp_point_x,
   output logic signed [31:0]  rsp_point_y,
   output logic signed [17:0]  rsp_normal_x,
   output logic signed [17:0]  rsp_normal_y,
   output logic [30:0]         rsp_hit_distance,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [rsi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]         csr_data
);

   localparam int QW    = rsi_pkg::QINT_W + FRAC_BITS;
   localparam int LO_W  = QW / 2;
   localparam int HI_W  = QW - LO_W;
   localparam int PL_W  = 32 + LO_W + 1;
   localparam int PH_W  = 32 + HI_W + 1;
   localparam int PW    = 32 + QW + 1;
   localparam int SW    = PW + 1;
   localparam int BW    = 31 + FRAC_BITS - 1;
   localparam int CW    = ((52 > BW) ? 52 : BW) + 1;
   localparam logic [17:0] DIR_ONE = 18'((64'd1 << FRAC_BITS));
   localparam logic [30:0] LEN_ONE = 31'((64'd1 << FRAC_BITS));

   // Segment registers.
   logic signed [31:0] center_x_ff, center_y_ff;
   logic signed [17:0] dir_x_ff, dir_y_ff;
   logic [30:0]        length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         dir_x_ff    <= DIR_ONE;
         dir_y_ff    <= '0;
         length_ff   <= LEN_ONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rsi_pkg::CSR_CENTER_X: center_x_ff <= csr_data;
            rsi_pkg::CSR_CENTER_Y: center_y_ff <= csr_data;
            rsi_pkg::CSR_DIR_X:    dir_x_ff    <= csr_data[17:0];
            rsi_pkg::CSR_DIR_Y:    dir_y_ff    <= csr_data[17:0];
            rsi_pkg::CSR_LENGTH:   length_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves as a whole whenever the output register can take a response.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: ray origin relative to the segment centre.
   logic               v1_ff;
   logic signed [32:0] dox1_ff, doy1_ff;
   logic signed [31:0] ox1_ff, oy1_ff, dx1_ff, dy1_ff;

   // Stage 2: the four cross-product terms.
   logic               v2_ff;
   logic signed [50:0] m1_2_ff, m2_2_ff, m3_2_ff, m4_2_ff;
   logic signed [31:0] ox2_ff, oy2_ff, dx2_ff, dy2_ff;

   // Stage 3: numerator and denominator of the ray parameter.
   logic               v3_ff;
   logic signed [51:0] num3_ff;
   logic signed [50:0] den3_ff;
   logic signed [31:0] ox3_ff, oy3_ff, dx3_ff, dy3_ff;

   // Stage 4: magnitudes for the divider and the early rejections.
   rsi_pkg::rsi_flow_type     flow4_ff;
   logic [rsi_pkg::AN_W-1:0]  an4_ff;
   logic [rsi_pkg::AD_W-1:0]  ad4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         flow4_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff          <= req_valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         flow4_ff.valid <= v3_ff;
      end
      if (adv) begin
         dox1_ff <= 33'(req_ray_origin_x) - 33'(center_x_ff);
         doy1_ff <= 33'(req_ray_origin_y) - 33'(center_y_ff);
         ox1_ff  <= req_ray_origin_x;
         oy1_ff  <= req_ray_origin_y;
         dx1_ff  <= req_ray_dir_x;
         dy1_ff  <= req_ray_dir_y;

         m1_2_ff <= 51'(dir_x_ff) * 51'(doy1_ff);
         m2_2_ff <= 51'(dir_y_ff) * 51'(dox1_ff);
         m3_2_ff <= 51'(dx1_ff) * 51'(dir_y_ff);
         m4_2_ff <= 51'(dy1_ff) * 51'(dir_x_ff);
         ox2_ff  <= ox1_ff;
         oy2_ff  <= oy1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;

         num3_ff <= 52'(m1_2_ff) - 52'(m2_2_ff);
         den3_ff <= m3_2_ff - m4_2_ff;
         ox3_ff  <= ox2_ff;
         oy3_ff  <= oy2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;

         // A parallel ray, or a segment that lies behind the origin, cannot hit.
         an4_ff <= num3_ff[51] ? 52'(-num3_ff) : 52'(num3_ff);
         ad4_ff <= den3_ff[50] ? 51'(-den3_ff) : 51'(den3_ff);
         flow4_ff.side.ox      <= ox3_ff;
         flow4_ff.side.oy      <= oy3_ff;
         flow4_ff.side.dx      <= dx3_ff;
         flow4_ff.side.dy      <= dy3_ff;
         flow4_ff.side.reject  <= (den3_ff == '0) ||
                                  ((num3_ff != '0) && (num3_ff[51] != den3_ff[50]));
         flow4_ff.side.den_pos <= !den3_ff[50];
      end
   end

   // Divider: ray parameter as an unsigned fixed-point quotient.
   rsi_pkg::rsi_flow_type div_flow;
   logic [QW-1:0]         div_quo;
   logic                  div_big;

   rsi_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_flow  (flow4_ff),
      .in_an    (an4_ff),
      .in_ad    (ad4_ff),
      .out_flow (div_flow),
      .out_quo  (div_quo),
      .out_big  (div_big)
   );

   // Stage 6: partial products of direction and quotient, saturated distance.
   logic                 v6_ff, rej6_ff, dpos6_ff;
   logic [30:0]          dist6_ff;
   logic signed [31:0]   ox6_ff, oy6_ff;
   logic signed [PL_W-1:0] plx6_ff, ply6_ff;
   logic signed [PH_W-1:0] phx6_ff, phy6_ff;

   // Stage 7: full products.
   logic                 v7_ff, rej7_ff, dpos7_ff;
   logic [30:0]          dist7_ff;
   logic signed [31:0]   ox7_ff, oy7_ff;
   logic signed [PW-1:0] prx7_ff, pry7_ff;

   // Stage 8: hit point, with the range check folded into the rejection.
   logic                 v8_ff, rej8_ff, dpos8_ff;
   logic [30:0]          dist8_ff;
   logic signed [31:0]   px8_ff, py8_ff;

   // Stage 9: hit point relative to the centre.
   logic                 v9_ff, rej9_ff, dpos9_ff;
   logic [30:0]          dist9_ff;
   logic signed [31:0]   px9_ff, py9_ff;
   logic signed [32:0]   dpx9_ff, dpy9_ff;

   // Stage 10: terms of the position along the segment.
   logic                 v10_ff, rej10_ff, dpos10_ff;
   logic [30:0]          dist10_ff;
   logic signed [31:0]   px10_ff, py10_ff;
   logic signed [50:0]   a1_10_ff, a2_10_ff;

   logic [LO_W-1:0]      quo_lo;
   logic [HI_W-1:0]      quo_hi;
   logic signed [SW-1:0] sx_in, sy_in;
   logic                 okx, oky;

   assign quo_lo = div_quo[LO_W-1:0];
   assign quo_hi = div_quo[QW-1:LO_W];

   // Floor of the product plus the origin; the shift is arithmetic so it rounds down.
   assign sx_in = SW'(ox7_ff) + SW'(prx7_ff >>> FRAC_BITS);
   assign sy_in = SW'(oy7_ff) + SW'(pry7_ff >>> FRAC_BITS);
   assign okx   = (sx_in[SW-1:31] == '0) || (sx_in[SW-1:31] == '1);
   assign oky   = (sy_in[SW-1:31] == '0) || (sy_in[SW-1:31] == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v6_ff  <= div_flow.valid;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
      if (adv) begin
         // A quotient of 2^32 or more moves any non-zero direction out of range.
         rej6_ff  <= div_flow.side.reject || div_big;
         dpos6_ff <= div_flow.side.den_pos;
         dist6_ff <= (div_quo > QW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : div_quo[30:0];
         ox6_ff   <= div_flow.side.ox;
         oy6_ff   <= div_flow.side.oy;
         plx6_ff  <= PL_W'(div_flow.side.dx) * PL_W'($signed({1'b0, quo_lo}));
         ply6_ff  <= PL_W'(div_flow.side.dy) * PL_W'($signed({1'b0, quo_lo}));
         phx6_ff  <= PH_W'(div_flow.side.dx) * PH_W'($signed({1'b0, quo_hi}));
         phy6_ff  <= PH_W'(div_flow.side.dy) * PH_W'($signed({1'b0, quo_hi}));

         rej7_ff  <= rej6_ff;
         dpos7_ff <= dpos6_ff;
         dist7_ff <= dist6_ff;
         ox7_ff   <= ox6_ff;
         oy7_ff   <= oy6_ff;
         prx7_ff  <= (PW'(phx6_ff) <<< LO_W) + PW'(plx6_ff);
         pry7_ff  <= (PW'(phy6_ff) <<< LO_W) + PW'(ply6_ff);

         rej8_ff  <= rej7_ff || !okx || !oky;
         dpos8_ff <= dpos7_ff;
         dist8_ff <= dist7_ff;
         px8_ff   <= sx_in[31:0];
         py8_ff   <= sy_in[31:0];

         rej9_ff  <= rej8_ff;
         dpos9_ff <= dpos8_ff;
         dist9_ff <= dist8_ff;
         px9_ff   <= px8_ff;
         py9_ff   <= py8_ff;
         dpx9_ff  <= 33'(px8_ff) - 33'(center_x_ff);
         dpy9_ff  <= 33'(py8_ff) - 33'(center_y_ff);

         rej10_ff  <= rej9_ff;
         dpos10_ff <= dpos9_ff;
         dist10_ff <= dist9_ff;
         px10_ff   <= px9_ff;
         py10_ff   <= py9_ff;
         a1_10_ff  <= 51'(dpx9_ff) * 51'(dir_x_ff);
         a2_10_ff  <= 51'(dpy9_ff) * 51'(dir_y_ff);
      end
   end

   // Output stage: the bound test, in which the segment ends count as inside.
   logic signed [CW-1:0] along;
   logic signed [CW-1:0] bound;
   logic                 in_bounds;
   logic                 hit;

   assign along     = CW'(52'(a1_10_ff) + 52'(a2_10_ff));
   assign bound     = CW'($signed({1'b0, length_ff, {(FRAC_BITS-1){1'b0}}}));
   assign in_bounds = !(along > bound) && !(along < -bound);
   assign hit       = !rej10_ff && in_bounds;

   logic               rsp_hit_ff;
   logic signed [31:0] rsp_point_x_ff, rsp_point_y_ff;
   logic signed [17:0] rsp_normal_x_ff, rsp_normal_y_ff;
   logic [30:0]        rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v10_ff;
      end
      if (adv) begin
         rsp_hit_ff      <= hit;
         rsp_point_x_ff  <= hit ? px10_ff : '0;
         rsp_point_y_ff  <= hit ? py10_ff : '0;
         rsp_dist_ff     <= hit ? dist10_ff : '0;
         // The normal is the perpendicular of the segment direction, turned to the ray.
         if (!hit) begin
            rsp_normal_x_ff <= '0;
            rsp_normal_y_ff <= '0;
         end else if (dpos10_ff) begin
            rsp_normal_x_ff <= 18'(-dir_y_ff);
            rsp_normal_y_ff <= dir_x_ff;
         end else begin
            rsp_normal_x_ff <= dir_y_ff;
            rsp_normal_y_ff <= 18'(-dir_x_ff);
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_point_x      = rsp_point_x_ff;
   assign rsp_point_y      = rsp_point_y_ff;
   assign rsp_normal_x     = rsp_normal_x_ff;
   assign rsp_normal_y     = rsp_normal_y_ff;
   assign rsp_hit_distance = rsp_dist_ff;

endmodule

FILE: rtl/rsi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the intersection core and its bind.
module rsi_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic signed [31:0]  req_ray_origin_x,
   input logic signed [31:0]  req_ray_origin_y,
   input logic signed [31:0]  req_ray_dir_x,
   input logic signed [31:0]  req_ray_dir_y,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_hit,
   input logic signed [31:0]  rsp_point_x,
   input logic signed [31:0]  rsp_point_y,
   input logic signed [17:0]  rsp_normal_x,
   input logic signed [17:0]  rsp_normal_y,
   input logic [30:0]         rsp_hit_distance,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [rsi_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [31:0]         csr_data
);

   // A stalled response stays valid and keeps its point, hit flag and distance.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) &&
      $stable(rsp_point_y) && $stable(rsp_hit) && $stable(rsp_hit_distance))
      else $error("response changed while stalled");

   // A miss reports all fields as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_point_x == '0 && rsp_point_y == '0 &&
      rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_hit_distance == '0)
      else $error("miss with non-zero fields");

   // Requests are held back only by a stalled response.
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ray_segment_intersect_core rsi_checker u_rsi_checker (.*);
